@@ src/mqts_pkg.sv @@
// Shared types and constants for the two-stack maximum queue.
`timescale 1ns / 1ps

package mqts_pkg;

    // Fixed widths of the channel fields
    localparam int IO_VALUE_W = 32;
    localparam int COUNT_W    = 11;

    // Command codes carried on the request channel
    typedef enum logic
    {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } op_t;

    // Result error codes
    typedef enum logic [1:0]
    {
        ERR_OK        = 2'd0,
        ERR_POP_EMPTY = 2'd1,
        ERR_PUSH_FULL = 2'd2
    } err_t;

    // Commands from the controller to the datapath
    typedef struct packed
    {
        logic push;      // write the request value onto the back stack
        logic pop;       // drop the top of the front stack
        logic xfer_run;  // move back stack entries onto the front stack
        logic load_top;  // take the new front top maximum from memory
        logic emit;      // load the result register
        logic err_load;  // capture the error code below
        err_t err;
    } mqts_ctrl_t;

    // Status from the datapath to the controller
    typedef struct packed
    {
        logic empty;
        logic full;
        logic front_zero;
        logic xfer_done;
    } mqts_stat_t;

endpackage

@@ src/mqts_if.sv @@
// Request and response channel interfaces for the two-stack maximum queue.
`timescale 1ns / 1ps

interface mqts_req_if import mqts_pkg::*; ();
    logic                         valid;
    logic                         ready;
    op_t                          cmd;
    logic signed [IO_VALUE_W-1:0] value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface mqts_rsp_if import mqts_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic signed [IO_VALUE_W-1:0] queue_max;
    logic [COUNT_W-1:0]           count;
    logic                         is_empty;
    err_t                         error;

    modport source (output valid, output queue_max, output count, output is_empty,
                    output error, input ready);
    modport sink   (input valid, input queue_max, input count, input is_empty,
                    input error, output ready);
endinterface

@@ src/mqts_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mqts_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

@@ src/mqts_datapath.sv @@
// Datapath: both stacks, their counts, top maxima and the result register.
`timescale 1ns / 1ps

module mqts_datapath import mqts_pkg::*; #(
    parameter int DEPTH      = 1024,
    parameter int VALUE_BITS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mqts_ctrl_t                   ctrl,
    output mqts_stat_t                   stat,
    input  logic signed [IO_VALUE_W-1:0] value,
    output logic signed [IO_VALUE_W-1:0] queue_max,
    output logic [COUNT_W-1:0]           count,
    output logic                         is_empty,
    output err_t                         error
);

    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int ENTRY_W = 2 * VALUE_BITS;

    logic [CNT_W-1:0]              bc_reg, bc_next;
    logic [CNT_W-1:0]              fc_reg, fc_next;
    logic signed [VALUE_BITS-1:0]  bmax_reg, bmax_next;
    logic signed [VALUE_BITS-1:0]  fmax_reg, fmax_next;
    logic                          pend_reg, pend_next;
    err_t                          err_reg, err_next;
    logic signed [IO_VALUE_W-1:0]  qmax_reg, qmax_next;
    logic [COUNT_W-1:0]            cnt_reg, cnt_next;
    logic                          empty_reg, empty_next;
    err_t                          error_reg, error_next;

    logic                          back_we, front_we;
    logic [ADDR_W-1:0]             back_waddr, back_raddr, front_waddr, front_raddr;
    logic [ENTRY_W-1:0]            back_wdata, back_rdata, front_wdata, front_rdata;

    logic [CNT_W-1:0]              bc_dec, fc_dec2, total;
    logic [CNT_W+COUNT_W-1:0]      total_ext;
    logic signed [VALUE_BITS-1:0]  push_val, push_max, xfer_val, xfer_max, qmax;

    mqts_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_back_ram (
        .clk   (clk),
        .we    (back_we),
        .waddr (back_waddr),
        .wdata (back_wdata),
        .raddr (back_raddr),
        .rdata (back_rdata)
    );

    mqts_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_front_ram (
        .clk   (clk),
        .we    (front_we),
        .waddr (front_waddr),
        .wdata (front_wdata),
        .raddr (front_raddr),
        .rdata (front_rdata)
    );

    // Running maxima for a push and for one transferred entry
    assign push_val = $signed(value[VALUE_BITS-1:0]);
    assign push_max = (bc_reg == '0 || push_val > bmax_reg) ? push_val : bmax_reg;
    assign xfer_val = $signed(back_rdata[VALUE_BITS-1:0]);
    assign xfer_max = (fc_reg == '0 || xfer_val > fmax_reg) ? xfer_val : fmax_reg;

    // Stack addresses: write at the count; the back stack reads its top, the front stack reads just below its top
    assign bc_dec      = bc_reg - CNT_W'(1);
    assign fc_dec2     = fc_reg - CNT_W'(2);
    assign back_waddr  = bc_reg[ADDR_W-1:0];
    assign back_raddr  = bc_dec[ADDR_W-1:0];
    assign back_wdata  = {push_max, push_val};
    assign front_waddr = fc_reg[ADDR_W-1:0];
    assign front_raddr = fc_dec2[ADDR_W-1:0];
    assign front_wdata = {xfer_max, xfer_val};

    // Queue totals and maximum
    assign total     = bc_reg + fc_reg;
    assign total_ext = {{COUNT_W{1'b0}}, total};

    always_comb
    begin
        if (bc_reg == '0)
        begin
            qmax = (fc_reg == '0) ? '0 : fmax_reg;
        end
        else if (fc_reg == '0)
        begin
            qmax = bmax_reg;
        end
        else
        begin
            qmax = (bmax_reg > fmax_reg) ? bmax_reg : fmax_reg;
        end
    end

    // Status to the controller
    assign stat.empty      = (total == '0);
    assign stat.full       = (total == CNT_W'(DEPTH));
    assign stat.front_zero = (fc_reg == '0);
    assign stat.xfer_done  = (bc_reg == '0) && !pend_reg;

    // Next-state logic for counts, maxima and the result register
    always_comb
    begin
        bc_next    = bc_reg;
        fc_next    = fc_reg;
        bmax_next  = bmax_reg;
        fmax_next  = fmax_reg;
        err_next   = err_reg;
        qmax_next  = qmax_reg;
        cnt_next   = cnt_reg;
        empty_next = empty_reg;
        error_next = error_reg;
        back_we    = 1'b0;
        front_we   = 1'b0;
        pend_next  = ctrl.xfer_run && (bc_reg != '0);

        if (ctrl.push)
        begin
            back_we   = 1'b1;
            bc_next   = bc_reg + CNT_W'(1);
            bmax_next = push_max;
        end

        // Read one back entry per cycle, write it onto the front stack in the following cycle
        if (ctrl.xfer_run)
        begin
            if (bc_reg != '0)
            begin
                bc_next = bc_dec;
            end
            if (pend_reg)
            begin
                front_we  = 1'b1;
                fc_next   = fc_reg + CNT_W'(1);
                fmax_next = xfer_max;
            end
        end

        if (ctrl.pop)
        begin
            fc_next = fc_reg - CNT_W'(1);
        end

        if (ctrl.load_top)
        begin
            fmax_next = $signed(front_rdata[ENTRY_W-1:VALUE_BITS]);
        end

        if (ctrl.err_load)
        begin
            err_next = ctrl.err;
        end

        if (ctrl.emit)
        begin
            qmax_next  = IO_VALUE_W'(qmax);
            cnt_next   = total_ext[COUNT_W-1:0];
            empty_next = (total == '0);
            error_next = err_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bc_reg   <= '0;
            fc_reg   <= '0;
            pend_reg <= 1'b0;
        end
        else
        begin
            bc_reg   <= bc_next;
            fc_reg   <= fc_next;
            pend_reg <= pend_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        bmax_reg  <= bmax_next;
        fmax_reg  <= fmax_next;
        err_reg   <= err_next;
        qmax_reg  <= qmax_next;
        cnt_reg   <= cnt_next;
        empty_reg <= empty_next;
        error_reg <= error_next;
    end

    assign queue_max = qmax_reg;
    assign count     = cnt_reg;
    assign is_empty  = empty_reg;
    assign error     = error_reg;

endmodule

@@ src/mqts_ctrl.sv @@
// Controller: sequences push, pop, stack transfer and result hand-off.
`timescale 1ns / 1ps

module mqts_ctrl import mqts_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  op_t        req_cmd,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    input  mqts_stat_t stat,
    output mqts_ctrl_t ctrl
);

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_XFER,
        ST_LOAD,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   valid_reg, valid_next;
    logic   accept, slot_free;

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign slot_free = !valid_reg || rsp_ready;

    // Decode state and status into datapath commands
    always_comb
    begin
        ctrl       = '0;
        ctrl.err   = ERR_OK;
        state_next = state_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ctrl.err_load = 1'b1;
                    state_next    = ST_EMIT;
                    if (req_cmd == OP_PUSH)
                    begin
                        if (stat.full)
                        begin
                            ctrl.err = ERR_PUSH_FULL;
                        end
                        else
                        begin
                            ctrl.push = 1'b1;
                        end
                    end
                    else if (stat.empty)
                    begin
                        ctrl.err = ERR_POP_EMPTY;
                    end
                    else if (stat.front_zero)
                    begin
                        state_next = ST_XFER;
                    end
                    else
                    begin
                        ctrl.pop   = 1'b1;
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_XFER:
            begin
                ctrl.xfer_run = 1'b1;
                if (stat.xfer_done)
                begin
                    ctrl.pop   = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                ctrl.load_top = 1'b1;
                state_next    = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    ctrl.emit  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the result valid until the transaction completes
    always_comb
    begin
        if (ctrl.emit)
        begin
            valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    assign rsp_valid = valid_reg;

endmodule

@@ src/max_queue_two_stacks.sv @@
// Top level of the two-stack maximum queue.
//
// A FIFO of signed values that reports its maximum after every command.
// Request channel (req): cmd selects push (value enqueued, narrowed to
// VALUE_BITS and sign-extended) or pop (front value dropped).
// Response channel (rsp): one transaction per request with the queue
// maximum (0 when empty), the count, an empty flag and an error code
// (pop on an empty queue or push on a full queue is ignored and flagged).
// Steps per request, from acceptance to the load of the result register:
//   push or rejected command: accept, then emit;
//   pop with a non-empty front stack: accept and pop, load the new top, emit;
//   pop that first moves the back stack entries: accept, transfer, then pop,
//   load the new top, emit.
// The transfer is bounded by the single read port of the back stack RAM,
// one entry per cycle; each value moves once. One request is in work at
// a time. The result register lets the next request be taken while a
// result waits; a stalled receiver holds the block in its hand-off step.
// Reset empties both stacks at once; the RAMs are not cleared.
`timescale 1ns / 1ps

module max_queue_two_stacks import mqts_pkg::*; #(
    parameter int DEPTH      = 1024,
    parameter int VALUE_BITS = 32
) (
    input logic        clk,
    input logic        rst_n,
    mqts_req_if.sink   req,
    mqts_rsp_if.source rsp
);

    mqts_ctrl_t ctrl;
    mqts_stat_t stat;

    // Sequence each transaction
    mqts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .req_cmd   (req.cmd),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    // Hold the stacks and the result
    mqts_datapath #(.DEPTH(DEPTH), .VALUE_BITS(VALUE_BITS)) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .stat      (stat),
        .value     (req.value),
        .queue_max (rsp.queue_max),
        .count     (rsp.count),
        .is_empty  (rsp.is_empty),
        .error     (rsp.error)
    );

endmodule

@@ src/mqts_checker.sv @@
// Port-level assertions for the two-stack maximum queue, bound to the top level.
`timescale 1ns / 1ps

module mqts_checker import mqts_pkg::*; (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic signed [IO_VALUE_W-1:0] rsp_queue_max,
    input logic [COUNT_W-1:0]           rsp_count,
    input logic                         rsp_is_empty,
    input err_t                         rsp_error
);

    // A stalled result stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    // An empty queue reports zero count and zero maximum
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_is_empty |-> rsp_count == '0 && rsp_queue_max == '0)
        else $error("empty queue with non-zero count or maximum");

    // A rejected pop only happens on an empty queue
    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_error == ERR_POP_EMPTY |-> rsp_is_empty)
        else $error("pop rejected on a non-empty queue");

    // A dropped push never reports an empty queue
    a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_error == ERR_PUSH_FULL |-> !rsp_is_empty)
        else $error("push dropped on an empty queue");

endmodule

bind max_queue_two_stacks mqts_checker u_mqts_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_queue_max (rsp.queue_max),
    .rsp_count     (rsp.count),
    .rsp_is_empty  (rsp.is_empty),
    .rsp_error     (rsp.error)
);

@@ verif/tb_top.sv @@
// Self-checking testbench for the two-stack maximum queue.
`timescale 1ns / 1ps

module tb_top;
    import mqts_pkg::*;

    localparam int  QDEPTH       = 1024;
    localparam int  VBITS        = 32;
    localparam time CLK_PERIOD   = 8ns;
    localparam int  CYCLE_LIMIT  = 400000;
    localparam int  SETTLE_TICKS = 16;

    // Queue status expected after one command
    typedef struct {
        logic signed [IO_VALUE_W-1:0] queue_max;
        logic [COUNT_W-1:0]           count;
        logic                         is_empty;
        err_t                         error;
    } status_t;

    // Shadow of the two stacks; works out the status after each command
    class maxq_tracker;
        logic signed [IO_VALUE_W-1:0] back_val [QDEPTH];
        logic signed [IO_VALUE_W-1:0] back_mx  [QDEPTH];
        logic signed [IO_VALUE_W-1:0] front_val[QDEPTH];
        logic signed [IO_VALUE_W-1:0] front_mx [QDEPTH];
        int unsigned back_cnt;
        int unsigned front_cnt;
        status_t     pending_status[$];
        int unsigned results_seen;
        int unsigned mismatches;
        int unsigned n_push;
        int unsigned n_pop;
        int unsigned n_full;
        int unsigned n_empty;
        int unsigned peak;

        function new();
            back_cnt     = 0;
            front_cnt    = 0;
            results_seen = 0;
            mismatches   = 0;
            n_push       = 0;
            n_pop        = 0;
            n_full       = 0;
            n_empty      = 0;
            peak         = 0;
        endfunction

        function int unsigned occupancy();
            return back_cnt + front_cnt;
        endfunction

        // Apply one accepted command and queue the status it must produce
        function void note_command(op_t op, logic signed [IO_VALUE_W-1:0] v);
            logic signed [IO_VALUE_W-1:0] nv;
            logic signed [IO_VALUE_W-1:0] m;
            status_t                      s;
            s.error = ERR_OK;
            if (op == OP_PUSH)
            begin
                n_push++;
                if (occupancy() >= QDEPTH)
                begin
                    s.error = ERR_PUSH_FULL;
                    n_full++;
                end
                else
                begin
                    // narrow to the value width and sign-extend
                    nv = (v <<< (IO_VALUE_W - VBITS)) >>> (IO_VALUE_W - VBITS);
                    m  = nv;
                    if (back_cnt > 0 && back_mx[back_cnt-1] > m)
                        m = back_mx[back_cnt-1];
                    back_val[back_cnt] = nv;
                    back_mx[back_cnt]  = m;
                    back_cnt++;
                end
            end
            else
            begin
                n_pop++;
                if (occupancy() == 0)
                begin
                    s.error = ERR_POP_EMPTY;
                    n_empty++;
                end
                else
                begin
                    // refill an empty front stack from the back stack, top first, rebuilding the running maxima
                    if (front_cnt == 0)
                    begin
                        while (back_cnt > 0 && front_cnt < QDEPTH)
                        begin
                            nv = back_val[back_cnt-1];
                            m  = nv;
                            if (front_cnt > 0 && front_mx[front_cnt-1] > m)
                                m = front_mx[front_cnt-1];
                            front_val[front_cnt] = nv;
                            front_mx[front_cnt]  = m;
                            front_cnt++;
                            back_cnt--;
                        end
                    end
                    front_cnt--;
                end
            end
            if (occupancy() > peak)
                peak = occupancy();

            // queue maximum is the larger of the two top running maxima
            if (occupancy() == 0)
                s.queue_max = '0;
            else if (back_cnt == 0)
                s.queue_max = front_mx[front_cnt-1];
            else if (front_cnt == 0)
                s.queue_max = back_mx[back_cnt-1];
            else
                s.queue_max = (back_mx[back_cnt-1] > front_mx[front_cnt-1])
                              ? back_mx[back_cnt-1] : front_mx[front_cnt-1];
            s.count    = COUNT_W'(occupancy());
            s.is_empty = (occupancy() == 0);
            pending_status.insert(pending_status.size(), s);
        endfunction

        function void flag(string what, logic [31:0] e, logic [31:0] g);
            mismatches++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, e, g);
        endfunction

        // Compare one response transaction with the oldest expectation
        function void check_status(logic signed [IO_VALUE_W-1:0] qmax,
                                   logic [COUNT_W-1:0] cnt, logic empty, err_t err);
            status_t e;
            results_seen++;
            if (pending_status.size() == 0)
            begin
                flag("unexpected result, queue_max", 'x, qmax);
                return;
            end
            e = pending_status.pop_front();
            if (qmax !== e.queue_max)
                flag("queue_max", e.queue_max, qmax);
            if (cnt !== e.count)
                flag("count", 32'(e.count), 32'(cnt));
            if (empty !== e.is_empty)
                flag("is_empty", 32'(e.is_empty), 32'(empty));
            if (err !== e.error)
                flag("error", 32'(e.error), 32'(err));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    mqts_req_if req_ch ();
    mqts_rsp_if rsp_ch ();

    maxq_tracker tracker;
    bit          bursts_on;
    int unsigned items_sent;
    int unsigned cycle_count;
    bit          long_hold_done;

    max_queue_two_stacks #(
        .DEPTH      (QDEPTH),
        .VALUE_BITS (VBITS)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("** max_queue_two_stacks: FAILED **");
            $finish;
        end
    end

    // Check every response transaction
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && tracker != null && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            tracker.check_status(rsp_ch.queue_max, rsp_ch.count, rsp_ch.is_empty, rsp_ch.error);
    end

    // Receiver: random stalls, one long hold-off to back the block up
    initial
    begin
        rsp_ch.ready <= 1'b0;
        do @(posedge clk); while (rst_n !== 1'b1);
        forever
        begin
            if (!long_hold_done && tracker.results_seen >= 60)
            begin
                long_hold_done = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (250) @(posedge clk);
            end
            else if (bursts_on && $urandom_range(0, 3) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    end

    function automatic logic signed [IO_VALUE_W-1:0] rand_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2, 3, 4: return int'($urandom_range(0, 16)) - 8;
            default: return $urandom();
        endcase
    endfunction

    // Offer one command and hold it until the block takes it
    task automatic send_cmd(input op_t op, input logic signed [IO_VALUE_W-1:0] v);
        int gap;
        gap = 0;
        if (bursts_on && (items_sent % 200) < 150 && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 6);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.cmd   <= op;
        req_ch.value <= v;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        tracker.note_command(op, v);
        items_sent++;
    endtask

    task automatic send_mixed(input int n, input int push_pct);
        repeat (n)
        begin
            if ($urandom_range(1, 100) <= push_pct)
                send_cmd(OP_PUSH, rand_value());
            else
                send_cmd(OP_POP, $urandom());
        end
    endtask

    initial
    begin
        tracker        = new();
        bursts_on      = 1'b1;
        items_sent     = 0;
        cycle_count    = 0;
        long_hold_done = 1'b0;
        rst_n        <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.cmd   <= OP_PUSH;
        req_ch.value <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty pops, extreme values, transfers, all-negative contents
        send_cmd(OP_POP, 32'sh1234_5678);
        send_cmd(OP_PUSH, 32'sh7FFF_FFFF);
        send_cmd(OP_PUSH, 32'sh8000_0000);
        send_cmd(OP_PUSH, -1);
        send_cmd(OP_PUSH, 0);
        send_cmd(OP_POP, 32'shFFFF_FFFF);
        send_cmd(OP_PUSH, 5);
        send_cmd(OP_POP, 0);
        send_cmd(OP_POP, 0);
        send_cmd(OP_POP, 0);
        send_cmd(OP_POP, 0);
        send_cmd(OP_POP, 0);
        send_cmd(OP_PUSH, -5);
        send_cmd(OP_PUSH, -3);
        send_cmd(OP_PUSH, 32'sh8000_0000);
        send_cmd(OP_PUSH, 32'shAAAA_AAAA);
        send_cmd(OP_PUSH, 32'sh5555_5555);
        send_cmd(OP_POP, 0);
        send_cmd(OP_PUSH, -3);
        send_cmd(OP_POP, 0);
        send_cmd(OP_POP, 0);
        send_cmd(OP_POP, 0);
        send_cmd(OP_POP, 0);
        send_cmd(OP_POP, 0);

        // Random: shallow mix around empty
        send_mixed(250, 55);

        // Fill to the brim, then push against a full queue
        while (tracker.occupancy() < QDEPTH)
            send_mixed(1, 95);
        repeat (12) send_cmd(OP_PUSH, rand_value());
        send_mixed(100, 50);

        // Drain mostly
        send_mixed(300, 20);

        // Final stretch without idling
        bursts_on = 1'b0;
        send_mixed(200, 35);
        req_ch.valid <= 1'b0;

        // Wait for outstanding results, then let the block settle
        while (tracker.pending_status.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);

        $display("Covered %0d pushes and %0d pops, with %0d pushes on a full queue",
                 tracker.n_push, tracker.n_pop, tracker.n_full);
        $display("and %0d pops on an empty one; peak fill %0d of %0d, %0d results checked",
                 tracker.n_empty, tracker.peak, QDEPTH, tracker.results_seen);
        if (tracker.mismatches == 0)
            $display("** max_queue_two_stacks: PASSED **");
        else
            $display("** max_queue_two_stacks: FAILED **");
        $finish;
    end

endmodule

@@ files.f @@
src/mqts_pkg.sv
src/mqts_if.sv
src/mqts_ram.sv
src/mqts_datapath.sv
src/mqts_ctrl.sv
src/max_queue_two_stacks.sv
src/mqts_checker.sv
verif/tb_top.sv
